@@ src/utf8_to_utf32_decoder_assert.svh @@
// assertion macros for the utf-8 to utf-32 decoder
// expects clk and rst to be visible where a macro is used
`ifndef UTF8_TO_UTF32_DECODER_ASSERT_SVH
`define UTF8_TO_UTF32_DECODER_ASSERT_SVH

// same-cycle implication
`define U2U_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U2U_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/u2u_pkg.sv @@
// shared types and constants for the utf-8 to utf-32 decoder
// no dependencies
package u2u_pkg;

  localparam int CP_W   = 21;
  localparam int QDEPTH = 2;

  localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP2  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP3  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP4  = 21'h010000;

  // length class of a pending sequence, picks its lowest legal code point
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_TWO  = 2'd1;
  localparam logic [1:0] CLS_THREE = 2'd2;
  localparam logic [1:0] CLS_FOUR = 2'd3;

  // results caused by one byte, one or two of them
  typedef struct packed {
    logic [CP_W-1:0] cp0;
    logic            repl0;
    logic [CP_W-1:0] cp1;
    logic            repl1;
    logic            two;
    logic            last;
  } bundle_t;

  function automatic logic seq_bad(input logic [CP_W-1:0] cp, input logic [1:0] cls);
    logic [CP_W-1:0] lo;
    begin
      case (cls)
        CLS_TWO:   lo = MIN_CP2;
        CLS_THREE: lo = MIN_CP3;
        default:   lo = MIN_CP4;
      endcase
      seq_bad = (cp < lo) || (cp > MAX_CP) || ((cp >= SURR_LO) && (cp <= SURR_HI));
    end
  endfunction

endpackage

@@ src/u2u_front.sv @@
// front end: accepts bytes, keeps the sequence state, builds result bundles
// depends on u2u_pkg
module u2u_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_req,
  input  logic              text_end,
  input  logic              q_full,
  output logic              push,
  output u2u_pkg::bundle_t  push_data
);
  import u2u_pkg::*;

  logic [CP_W-1:0] partial, partial_next;
  logic [1:0]      need, need_next;
  logic [1:0]      cls, cls_next;

  logic            accept;
  logic            pending, is_cont;
  logic            f_emit, f_repl;
  logic [CP_W-1:0] f_cp, f_val;
  logic [1:0]      f_need, f_cls;
  logic [CP_W-1:0] acc, x_cp, val_after;
  logic [1:0]      need_dec, need_after, cls_after;
  logic            x_repl, e0, e1, e2, bad;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pending  = (need != 2'd0);
  assign is_cont  = (byte_req[7:6] == 2'b10);
  assign acc      = {partial[CP_W-7:0], byte_req[5:0]};
  assign need_dec = need - 2'd1;
  assign bad      = seq_bad(acc, cls);

  // decode of a byte with no sequence pending
  always_comb begin
    f_emit = 1'b0;
    f_repl = 1'b0;
    f_cp   = {{(CP_W-8){1'b0}}, byte_req};
    f_val  = '0;
    f_need = 2'd0;
    f_cls  = CLS_NONE;
    if (byte_req[7] == 1'b0) begin
      f_emit = 1'b1;
    end else if (byte_req[7:5] == 3'b110) begin
      f_val  = {{(CP_W-5){1'b0}}, byte_req[4:0]};
      f_need = 2'd1;
      f_cls  = CLS_TWO;
    end else if (byte_req[7:4] == 4'b1110) begin
      f_val  = {{(CP_W-4){1'b0}}, byte_req[3:0]};
      f_need = 2'd2;
      f_cls  = CLS_THREE;
    end else if (byte_req[7:3] == 5'b11110) begin
      f_val  = {{(CP_W-3){1'b0}}, byte_req[2:0]};
      f_need = 2'd3;
      f_cls  = CLS_FOUR;
    end else begin
      // stray continuation or illegal lead
      f_emit = 1'b1;
      f_repl = 1'b1;
      f_cp   = REPL_CP;
    end
  end

  always_comb begin
    e0         = 1'b0;
    e1         = f_emit;
    x_cp       = f_cp;
    x_repl     = f_repl;
    need_after = f_need;
    val_after  = f_val;
    cls_after  = f_cls;
    if (pending && is_cont) begin
      if (need_dec == 2'd0) begin
        e1         = 1'b1;
        x_cp       = bad ? REPL_CP : acc;
        x_repl     = bad;
        need_after = 2'd0;
        val_after  = '0;
        cls_after  = CLS_NONE;
      end else begin
        e1         = 1'b0;
        need_after = need_dec;
        val_after  = acc;
        cls_after  = cls;
      end
    end else begin
      // broken sequence gives one replacement before the fresh decode
      e0 = pending;
    end
    // sequence left open at end of text
    e2 = text_end && (need_after != 2'd0);
  end

  always_comb begin
    push_data.cp0   = e0 ? REPL_CP : (e1 ? x_cp : REPL_CP);
    push_data.repl0 = e0 ? 1'b1 : (e1 ? x_repl : 1'b1);
    push_data.cp1   = e1 ? x_cp : REPL_CP;
    push_data.repl1 = e1 ? x_repl : 1'b1;
    push_data.two   = e0 && (e1 || e2);
    push_data.last  = text_end;
  end

  assign push = accept && (e0 || e1 || e2);

  always_comb begin
    partial_next = partial;
    need_next    = need;
    cls_next     = cls;
    if (accept) begin
      if (text_end) begin
        partial_next = '0;
        need_next    = 2'd0;
        cls_next     = CLS_NONE;
      end else begin
        partial_next = val_after;
        need_next    = need_after;
        cls_next     = cls_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      need    <= 2'd0;
      cls     <= CLS_NONE;
    end else begin
      partial <= partial_next;
      need    <= need_next;
      cls     <= cls_next;
    end
  end

endmodule

@@ src/u2u_queue.sv @@
// short bundle queue between front and back
// depends on u2u_pkg
module u2u_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u2u_pkg::bundle_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output u2u_pkg::bundle_t  pop_data
);
  import u2u_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  bundle_t          slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  assign full     = (count == CNT_W'(QDEPTH));
  assign q_valid  = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ src/u2u_back.sv @@
// back end: unpacks bundles into single code point transactions
// depends on u2u_pkg
module u2u_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  u2u_pkg::bundle_t           pop_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [u2u_pkg::CP_W-1:0]   code_point,
  output logic                       was_replaced,
  output logic                       run_last,
  output logic                       text_last
);
  import u2u_pkg::*;

  logic            take;
  logic            sec_pending;
  logic [CP_W-1:0] sec_cp;
  logic            sec_repl, sec_last;

  assign take = !out_valid || !out_stall;
  assign pop  = take && !sec_pending && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      sec_pending <= 1'b0;
    end else if (take) begin
      if (sec_pending) begin
        out_valid   <= 1'b1;
        sec_pending <= 1'b0;
      end else begin
        out_valid   <= q_valid;
        sec_pending <= q_valid && pop_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (sec_pending) begin
        code_point   <= sec_cp;
        was_replaced <= sec_repl;
        run_last     <= 1'b1;
        text_last    <= sec_last;
      end else if (pop) begin
        code_point   <= pop_data.cp0;
        was_replaced <= pop_data.repl0;
        run_last     <= !pop_data.two;
        text_last    <= pop_data.last && !pop_data.two;
        sec_cp       <= pop_data.cp1;
        sec_repl     <= pop_data.repl1;
        sec_last     <= pop_data.last;
      end
    end
  end

endmodule

@@ src/utf8_to_utf32_decoder.sv @@
// utf-8 byte stream to utf-32 code point decoder, top level
// depends on u2u_pkg, u2u_front, u2u_queue, u2u_back, utf8_to_utf32_decoder_assert.svh
//
//  channel | signals                                       | role
//  in      | in_valid, in_stall, byte_req, text_end        | one byte per transaction
//  out     | out_valid, out_stall, code_point, was_replaced, | one code point per transaction
//          | run_last, text_last                           |
//
// one byte is taken every cycle while the queue is not full; a byte that yields two
// code points holds the output register for both in turn and blocks the next pop
// path of a byte: front into a queue slot, then queue slot to the output register
// the two-entry bundle queue lets the front take bytes while out is stalled, until full
// rst is synchronous and active high and clears the sequence state and the queue
module utf8_to_utf32_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                byte_req,
  input  logic                      text_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [u2u_pkg::CP_W-1:0]  code_point,
  output logic                      was_replaced,
  output logic                      run_last,
  output logic                      text_last
);
  import u2u_pkg::*;

  `include "utf8_to_utf32_decoder_assert.svh"

  logic    q_full, q_valid, push, pop;
  bundle_t push_data, pop_data;

  u2u_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .byte_req  (byte_req),
    .text_end  (text_end),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  u2u_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data)
  );

  u2u_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .pop_data     (pop_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_point   (code_point),
    .was_replaced (was_replaced),
    .run_last     (run_last),
    .text_last    (text_last)
  );

  `U2U_ASSERT_IMP(a_pop_nonempty, pop, q_valid, "bundle popped from empty queue")

  `U2U_ASSERT_IMP(a_text_last_run, out_valid && text_last, run_last,
                  "text_last without run_last")

  `U2U_ASSERT_NEXT(a_second_follows, out_valid && !run_last && !out_stall,
                   out_valid && run_last, "second result of a byte did not follow")

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for utf8_to_utf32_decoder: directed byte table, then random texts
// depends on u2u_pkg and the decoder rtl; expected code points come from typed rows or an in-bench decoder
module tb;
  import u2u_pkg::*;

  localparam int N_DIR      = 24;
  localparam int N_BYTES    = 1150;
  localparam int LONG_HOLD  = 200;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 10;

  typedef struct {
    logic [7:0]      b;
    logic            fin;
    bit              typed;
    int              n;
    logic [CP_W-1:0] cp0;
    logic            r0;
    logic [CP_W-1:0] cp1;
    logic            r1;
  } text_byte_t;

  typedef struct {
    logic [CP_W-1:0] cp;
    logic            repl;
    logic            run_last;
    logic            text_last;
  } cp_result_t;

  logic            clk;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      byte_req = 8'h00;
  logic            text_end = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [CP_W-1:0] code_point;
  logic            was_replaced;
  logic            run_last;
  logic            text_last;

  utf8_to_utf32_decoder uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_req    (byte_req),
    .text_end    (text_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .was_replaced(was_replaced),
    .run_last    (run_last),
    .text_last   (text_last)
  );

  // directed bytes; typed rows carry their code points, the rest go through the decoder model
  text_byte_t dir_rows [N_DIR] = '{
    '{8'h00, 1'b0, 1'b1, 1, 21'h000000, 1'b0, 21'h0, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 1, 21'h00007F, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b1, 1, REPL_CP,    1'b1, 21'h0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1, REPL_CP,    1'b1, 21'h0, 1'b0},
    '{8'hC2, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    // overlong three byte form of zero
    '{8'hE0, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    // surrogate
    '{8'hED, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    // literal replacement char, not flagged
    '{8'hEF, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'hBD, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    // just above the unicode range
    '{8'hF4, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    // broken by an ascii byte
    '{8'hC3, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    // broken by a lead that is itself left open at end of text
    '{8'hC3, 1'b0, 1'b0, 0, 21'h0,      1'b0, 21'h0, 1'b0},
    '{8'hE2, 1'b1, 1'b1, 2, REPL_CP,    1'b1, REPL_CP, 1'b1},
    '{8'h41, 1'b1, 1'b1, 1, 21'h000041, 1'b0, 21'h0, 1'b0}
  };

  // decoder model state
  logic [CP_W-1:0] acc_val   = '0;
  logic [1:0]      cont_left = 2'd0;
  logic [1:0]      seq_cls   = CLS_NONE;

  cp_result_t step_out [$];
  cp_result_t pending_cps [$];
  text_byte_t offered [$];
  logic [7:0] seq_bytes [$];

  int  fails = 0;
  int  bytes_sent = 0;
  int  idle_cycles = 0;
  int  tx_run = 0;
  bit  tx_calm = 1'b0;
  bit  hold_out = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void add_cp(input logic [CP_W-1:0] cp, input logic repl);
    cp_result_t r;
    r.cp = cp;
    r.repl = repl;
    r.run_last = 1'b0;
    r.text_last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void clear_seq();
    acc_val = '0;
    cont_left = 2'd0;
    seq_cls = CLS_NONE;
  endfunction

  function automatic void open_seq(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      add_cp({13'd0, b}, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      acc_val = {16'd0, b[4:0]};
      cont_left = 2'd1;
      seq_cls = CLS_TWO;
    end else if (b[7:4] == 4'b1110) begin
      acc_val = {17'd0, b[3:0]};
      cont_left = 2'd2;
      seq_cls = CLS_THREE;
    end else if (b[7:3] == 5'b11110) begin
      acc_val = {18'd0, b[2:0]};
      cont_left = 2'd3;
      seq_cls = CLS_FOUR;
    end else begin
      add_cp(REPL_CP, 1'b1);
    end
  endfunction

  // fills step_out with the code points one byte produces, flags not yet set
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    logic [CP_W-1:0] lo;
    step_out.delete();
    if (cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        acc_val = {acc_val[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          case (seq_cls)
            CLS_TWO:   lo = MIN_CP2;
            CLS_THREE: lo = MIN_CP3;
            default:   lo = MIN_CP4;
          endcase
          if (acc_val < lo || acc_val > MAX_CP || (acc_val >= SURR_LO && acc_val <= SURR_HI))
            add_cp(REPL_CP, 1'b1);
          else
            add_cp(acc_val, 1'b0);
          clear_seq();
        end
      end else begin
        add_cp(REPL_CP, 1'b1);
        clear_seq();
        open_seq(b);
      end
    end else begin
      open_seq(b);
    end
    if (fin) begin
      if (cont_left != 2'd0) add_cp(REPL_CP, 1'b1);
      clear_seq();
    end
  endfunction

  // one random sequence: mostly well formed, some overlong, surrogate, too large,
  // truncated, stray or plain random bytes
  task automatic build_seq();
    int kind;
    int n;
    int drop;
    logic [CP_W-1:0] cp;
    seq_bytes.delete();
    kind = $urandom_range(0, 99);
    n = $urandom_range(1, 4);
    case (n)
      1: cp = CP_W'($urandom_range(0, 'h7F));
      2: cp = CP_W'($urandom_range('h80, 'h7FF));
      3: begin
        cp = CP_W'($urandom_range('h800, 'hFFFF));
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h002000;
      end
      default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
    endcase
    if ($urandom_range(0, 7) == 0) begin
      case (n)
        1: cp = $urandom_range(0, 1) ? 21'h00007F : 21'h000000;
        2: cp = $urandom_range(0, 1) ? 21'h0007FF : MIN_CP2;
        3: cp = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 21'h00FFFF : 21'h00D7FF)
                                     : ($urandom_range(0, 1) ? MIN_CP3 : 21'h00E000);
        default: cp = $urandom_range(0, 1) ? MAX_CP : MIN_CP4;
      endcase
    end
    if (kind >= 70 && kind < 78) begin
      n = $urandom_range(2, 4);
      cp = CP_W'((n == 2) ? $urandom_range(0, 'h7F) : (n == 3) ? $urandom_range(0, 'h7FF)
                                                               : $urandom_range(0, 'hFFFF));
    end else if (kind >= 78 && kind < 82) begin
      n = 3;
      cp = CP_W'($urandom_range(SURR_LO, SURR_HI));
    end else if (kind >= 82 && kind < 86) begin
      n = 4;
      cp = CP_W'($urandom_range('h110000, 'h1FFFFF));
    end
    case (n)
      1: seq_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        seq_bytes.push_back({3'b110, cp[10:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq_bytes.push_back({4'b1110, cp[15:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq_bytes.push_back({5'b11110, cp[20:18]});
        seq_bytes.push_back({2'b10, cp[17:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
    if (kind >= 86 && kind < 92 && n > 1) begin
      drop = $urandom_range(1, n - 1);
      repeat (drop) void'(seq_bytes.pop_back());
    end else if (kind >= 92 && kind < 96) begin
      seq_bytes.delete();
      seq_bytes.push_back(8'($urandom_range('h80, 'hBF)));
    end else if (kind >= 96) begin
      seq_bytes.delete();
      seq_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic offer_byte(input text_byte_t it);
    int gap;
    if (tx_run == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_run = $urandom_range(20, 80);
    end
    tx_run--;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered.push_back(it);
    in_valid <= 1'b1;
    byte_req <= it.b;
    text_end <= it.fin;
    do @(posedge clk); while (!(in_valid && !in_stall));
    bytes_sent++;
  endtask

  // byte source
  initial begin : tx_side
    text_byte_t it;
    int end_at;
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    do @(posedge clk); while (rst);
    foreach (dir_rows[i]) offer_byte(dir_rows[i]);
    while (bytes_sent < N_BYTES) begin
      if (!held && bytes_sent >= 400) begin
        // output held off while bytes keep coming back to back
        held = 1'b1;
        hold_out = 1'b1;
        tx_calm = 1'b1;
        tx_run = 100;
      end
      if (!paused && bytes_sent >= 800) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_cps.size() != 0);
      end
      build_seq();
      if ($urandom_range(0, 9) == 0) end_at = seq_bytes.size() - 1;
      else if ($urandom_range(0, 39) == 0) end_at = $urandom_range(0, seq_bytes.size() - 1);
      else end_at = -1;
      foreach (seq_bytes[k]) begin
        it = '{seq_bytes[k], (k == end_at), 1'b0, 0, 21'h0, 1'b0, 21'h0, 1'b0};
        offer_byte(it);
      end
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cps.size() != 0);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // code point sink
  initial begin : rx_side
    int gap;
    int run_left;
    bit calm;
    run_left = 0;
    calm = 1'b0;
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (run_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(20, 80);
      end
      run_left--;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : port_watch
    text_byte_t cur;
    cp_result_t tail;
    cp_result_t want;
    bit in_acc;
    bit out_acc;
    if (!rst) begin
      in_acc = in_valid && !in_stall;
      out_acc = out_valid && !out_stall;
      if (in_acc) begin
        cur = offered.pop_front();
        decode_byte(cur.b, cur.fin);
        if (cur.typed) begin
          step_out.delete();
          if (cur.n > 0) add_cp(cur.cp0, cur.r0);
          if (cur.n > 1) add_cp(cur.cp1, cur.r1);
        end
        if (step_out.size() > 0) begin
          tail = step_out.pop_back();
          tail.run_last = 1'b1;
          tail.text_last = cur.fin;
          step_out.push_back(tail);
        end
        foreach (step_out[k]) pending_cps.push_back(step_out[k]);
      end
      if (out_acc) begin
        if (pending_cps.size() == 0) begin
          $error("code point %h with no transaction expected", code_point);
          fails++;
        end else begin
          want = pending_cps.pop_front();
          if (code_point !== want.cp) begin
            $error("code_point expected %h got %h", want.cp, code_point);
            fails++;
          end
          if (was_replaced !== want.repl) begin
            $error("was_replaced expected %b got %b", want.repl, was_replaced);
            fails++;
          end
          if (run_last !== want.run_last) begin
            $error("run_last expected %b got %b", want.run_last, run_last);
            fails++;
          end
          if (text_last !== want.text_last) begin
            $error("text_last expected %b got %b", want.text_last, text_last);
            fails++;
          end
        end
      end
      if (in_acc || out_acc) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
